// ===== sv/sktab_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted key table search package
// Sizes, command and result types shared by the front, back and top level.
// ---------------------------------------------------------------------------
package sktab_pkg;

  // Table geometry.
  localparam int DEPTH     = 16384;
  localparam int KEY_BYTES = 5;
  localparam int KEY_W     = 40;
  localparam int IDX_W     = 14;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W   = $clog2(DEPTH + 1);

  // Only the low KEY_BYTES bytes of a key word take part in storage and compare.
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

  // Item kinds.
  typedef enum logic {
    KIND_APPEND = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  // A classified item as it waits between front and back.
  typedef struct packed {
    kind_t            kind;
    logic [KEY_W-1:0] key;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic             table_full;
  } result_t;

endpackage

// ===== sv/sorted_key_table_search_core.sv =====
// ---------------------------------------------------------------------------
// Sorted key table search core
// Key table with append and binary search lookup, queue-style on both sides.
// ---------------------------------------------------------------------------
// Usage: an item (kind, key_word) is transferred when push is high and full is
// low. kind selects append (store the key at the current count) or lookup
// (binary search over the keys held). Every item gives exactly one result:
// found, match_index and table_full, shown while empty is low and transferred
// when pop is high and empty is low. Keys must be appended in ascending order.
// Items pass through a two-entry command queue into the search engine, so
// push may go on while a result waits. An append writes its key if there is
// room and sets the result register as the engine takes it; a lookup first
// makes P probes, where P is up to log2(count) + 1 (15 at full depth). The
// engine reads the key table once per cycle, one probe per read, and that
// single read port sets the lookup rate. A new item starts only once the
// previous result has been transferred, so the engine works on one item at
// a time. A stalled receiver stops the engine and, after two more items,
// raises full. Reset empties both queues and sets the key count to zero;
// table contents are not cleared, and only entries below the count are ever
// read.
// ---------------------------------------------------------------------------
module sorted_key_table_search_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        kind,
  input  logic [sktab_pkg::KEY_W-1:0] key_word,
  output logic                        empty,
  input  logic                        pop,
  output logic                        found,
  output logic [sktab_pkg::IDX_W-1:0] match_index,
  output logic                        table_full
);
  import sktab_pkg::*;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  logic    res_valid;
  result_t res;

  // Front end: accept and classify items.
  sktab_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .key_word  (key_word),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back end: table storage and search engine.
  sktab_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  // Result side.
  assign empty       = !res_valid;
  assign found       = res.found;
  assign match_index = res.match_index;
  assign table_full  = res.table_full;

endmodule

// ===== sv/sktab_front.sv =====
// ---------------------------------------------------------------------------
// Sorted key table search front end
// Accepts items, masks the key and holds them in a two-entry command queue.
// ---------------------------------------------------------------------------
module sktab_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        kind,
  input  logic [sktab_pkg::KEY_W-1:0] key_word,
  output logic                        cmd_valid,
  output sktab_pkg::cmd_t             cmd,
  input  logic                        cmd_pop
);
  import sktab_pkg::*;

  cmd_t             q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push_ok;
  logic             pop_ok;
  cmd_t             cmd_in;

  // Classify the incoming item and trim the key to its used bytes.
  always_comb begin
    cmd_in.kind = kind_t'(kind);
    cmd_in.key  = key_word & KEY_MASK;
  end

  // The queue holds two entries, so a fill level of two means full.
  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_pop && cmd_valid;

  // Queue storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_ok && !pop_ok) begin
        fill <= fill + 2'd1;
      end else if (!push_ok && pop_ok) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== sv/sktab_back.sv =====
// ---------------------------------------------------------------------------
// Sorted key table search back end
// Holds the key table, appends keys and runs the binary search, one probe
// per cycle, into a single result register.
// ---------------------------------------------------------------------------
module sktab_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  sktab_pkg::cmd_t     cmd,
  output logic                cmd_pop,
  output logic                res_valid,
  output sktab_pkg::result_t  res,
  input  logic                res_pop
);
  import sktab_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  logic [KEY_W-1:0]   mem [DEPTH];
  logic [KEY_W-1:0]   rd_data;
  logic               wr_en;

  state_t             state, state_next;
  logic [COUNT_W-1:0] entry_count, entry_count_next;
  logic [COUNT_W-1:0] lo, lo_next;
  logic [COUNT_W-1:0] hx, hx_next;
  logic [COUNT_W-1:0] mid, mid_next;
  logic [KEY_W-1:0]   key, key_next;
  logic               res_valid_next;
  result_t            res_next;

  logic [COUNT_W-1:0] lo_up;
  logic [COUNT_W-1:0] mid_up;
  logic [COUNT_W-1:0] mid_dn;
  logic [COUNT_W-1:0] lo_new;
  logic [COUNT_W-1:0] hx_new;
  logic [COUNT_W-1:0] mid_new;

  // Both candidate next probes are formed from registered bounds, alongside the compare.
  assign lo_up  = mid + COUNT_W'(1);
  assign mid_up = lo_up + ((hx - COUNT_W'(1) - lo_up) >> 1);
  assign mid_dn = lo + ((mid - COUNT_W'(1) - lo) >> 1);

  // Next-state logic for append, search start and each probe.
  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    lo_next          = lo;
    hx_next          = hx;
    mid_next         = mid;
    key_next         = key;
    res_valid_next   = res_valid;
    res_next         = res;
    cmd_pop          = 1'b0;
    wr_en            = 1'b0;
    lo_new           = lo;
    hx_new           = hx;
    mid_new          = mid;

    if (res_pop && res_valid) begin
      res_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (cmd_valid && !res_valid) begin
          cmd_pop = 1'b1;
          if (cmd.kind == KIND_APPEND) begin
            res_valid_next = 1'b1;
            if (entry_count == COUNT_W'(DEPTH)) begin
              res_next = '{found: 1'b0, match_index: '0, table_full: 1'b1};
            end else begin
              wr_en            = 1'b1;
              res_next         = '{found: 1'b1, match_index: IDX_W'(entry_count),
                                   table_full: 1'b0};
              entry_count_next = entry_count + COUNT_W'(1);
            end
          end else begin
            key_next = cmd.key;
            if (entry_count == '0) begin
              res_valid_next = 1'b1;
              res_next       = '{found: 1'b0, match_index: '0, table_full: 1'b0};
            end else begin
              lo_next    = '0;
              hx_next    = entry_count;
              mid_next   = (entry_count - COUNT_W'(1)) >> 1;
              state_next = ST_SEARCH;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (rd_data == key) begin
          res_valid_next = 1'b1;
          res_next       = '{found: 1'b1, match_index: IDX_W'(mid), table_full: 1'b0};
          state_next     = ST_IDLE;
        end else begin
          if (rd_data < key) begin
            lo_new  = lo_up;
            hx_new  = hx;
            mid_new = mid_up;
          end else begin
            lo_new  = lo;
            hx_new  = mid;
            mid_new = mid_dn;
          end
          if (lo_new < hx_new) begin
            lo_next  = lo_new;
            hx_next  = hx_new;
            mid_next = mid_new;
          end else begin
            res_valid_next = 1'b1;
            res_next       = '{found: 1'b0, match_index: '0, table_full: 1'b0};
            state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Key table: one write port at the fill count, one registered read port at the next probe.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[entry_count[ADDR_W-1:0]] <= cmd.key;
    end
    rd_data <= mem[mid_next[ADDR_W-1:0]];
  end

  // Search datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hx  <= hx_next;
    mid <= mid_next;
    key <= key_next;
    res <= res_next;
  end

  // Control state and result flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      res_valid   <= res_valid_next;
    end
  end

  // The probe always lies inside a non-empty search window.
  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (lo < hx && mid >= lo && mid < hx))
    else $error("search probe outside its window");

  // A search only runs while the result register is free.
  a_search_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> !res_valid)
    else $error("search running with a result still waiting");

  // The fill count never passes the table depth.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    entry_count <= COUNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  // The fill count grows by at most one per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (entry_count == $past(entry_count) ||
                     entry_count == $past(entry_count) + COUNT_W'(1)))
    else $error("entry count jumped");

endmodule

// ===== dv/sktab_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Key table search checker
// Watches both queue ports of the search core, keeps its own copy of the key
// table, works out the result of every input transfer and compares each
// result transfer field by field with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module sktab_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        full,
  input  logic                        kind,
  input  logic [sktab_pkg::KEY_W-1:0] key_word,
  input  logic                        empty,
  input  logic                        pop,
  input  logic                        found,
  input  logic [sktab_pkg::IDX_W-1:0] match_index,
  input  logic                        table_full,
  output int                          fail_count,
  output int                          pending
);
  import sktab_pkg::*;

  // Mirror of the table held by the core.
  logic [KEY_W-1:0] key_store [DEPTH];
  int               key_count;

  // Results predicted but not yet seen on the result port.
  result_t          awaited_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    key_count  = 0;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Binary search over the entries held, with the same probe order as the
  // core, so that an unsorted table gives the same answer.
  function automatic result_t search_keys(input logic [KEY_W-1:0] key);
    result_t          res;
    int               lo;
    int               hi;
    int               mid;
    logic [KEY_W-1:0] probe;
    res = '0;
    lo  = 0;
    hi  = key_count - 1;
    while (lo <= hi) begin
      mid   = lo + (hi - lo) / 2;
      probe = key_store[mid] & KEY_MASK;
      if (probe < key) begin
        lo = mid + 1;
      end else if (probe > key) begin
        hi = mid - 1;
      end else begin
        res.found       = 1'b1;
        res.match_index = IDX_W'(mid);
        return res;
      end
    end
    return res;
  endfunction

  // Work out the result of one item and update the mirrored table.
  function automatic result_t table_outcome(input kind_t k,
                                            input logic [KEY_W-1:0] word);
    result_t          res;
    logic [KEY_W-1:0] key;
    res = '0;
    key = word & KEY_MASK;
    if (k == KIND_APPEND) begin
      if (key_count >= DEPTH) begin
        res.table_full = 1'b1;
      end else begin
        key_store[key_count] = key;
        res.found            = 1'b1;
        res.match_index      = IDX_W'(key_count);
        key_count++;
      end
    end else begin
      res = search_keys(key);
    end
    return res;
  endfunction

  // Result transfers are checked before the input transfer of the same edge
  // is predicted; the core cannot answer an item in the cycle it arrives.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      key_count = 0;
      awaited_results.delete();
    end else begin
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no item outstanding",
                          64'({found, match_index, table_full}), 64'(0));
        end else begin
          want = awaited_results.pop_front();
          if (found !== want.found)
            report_mismatch("found", 64'(found), 64'(want.found));
          if (match_index !== want.match_index)
            report_mismatch("match_index", 64'(match_index), 64'(want.match_index));
          if (table_full !== want.table_full)
            report_mismatch("table_full", 64'(table_full), 64'(want.table_full));
        end
      end
      if (push && !full) begin
        awaited_results.push_back(table_outcome(kind_t'(kind), key_word));
      end
    end
    pending <= awaited_results.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Key table search testbench
// Drives appends and lookups into the search core in bursts while the result
// side stalls on its own pattern. A short directed part covers an empty
// table, byte-order edges, duplicates and an unsorted entry; a random part
// appends ascending keys and looks up held, neighbouring and random keys;
// the table is then filled to the last entry and appends are refused.
// ---------------------------------------------------------------------------
module tb_top;
  import sktab_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 1500;
  localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};

  logic             clk;
  logic             rst         = 1'b1;
  logic             push        = 1'b0;
  logic             kind        = KIND_APPEND;
  logic [KEY_W-1:0] key_word    = '0;
  logic             pop         = 1'b0;
  logic             full;
  logic             empty;
  logic             found;
  logic [IDX_W-1:0] match_index;
  logic             table_full;

  int               fail_count;
  int               pending;
  int               cycle_count = 0;

  // Sender and receiver pacing.
  int               burst_left  = 0;
  int               stall_left  = 0;
  int               regime_left = 0;
  bit               stalls_on   = 1'b0;

  // Keys the core has accepted, in table order, and the next ascending key.
  logic [KEY_W-1:0] stored_keys [$];
  logic [KEY_W-1:0] next_key;

  sorted_key_table_search_core uut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .key_word   (key_word),
    .empty      (empty),
    .pop        (pop),
    .found      (found),
    .match_index(match_index),
    .table_full (table_full)
  );

  sktab_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .key_word   (key_word),
    .empty      (empty),
    .pop        (pop),
    .found      (found),
    .match_index(match_index),
    .table_full (table_full),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver alternates between calm stretches and stretches of random
  // stalls of varying length.
  always @(posedge clk) begin
    if (regime_left == 0) begin
      regime_left = $urandom_range(50, 400);
      stalls_on   = 1'($urandom_range(0, 1));
    end else begin
      regime_left--;
    end
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      if (stalls_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
    end
  end

  function automatic logic [KEY_W-1:0] random_key();
    return {8'($urandom_range(0, 255)), 32'($urandom)};
  endfunction

  // Offer one item and hold it until it is transferred. Bursts of random
  // length are separated by idle gaps.
  task automatic send_item(input kind_t k, input logic [KEY_W-1:0] key);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    push     <= 1'b1;
    kind     <= k;
    key_word <= key;
    do @(posedge clk); while (full !== 1'b0);
    burst_left--;
  endtask

  task automatic append_key(input logic [KEY_W-1:0] key);
    send_item(KIND_APPEND, key);
    if (stored_keys.size() < DEPTH) stored_keys.push_back(key);
  endtask

  task automatic lookup_key(input logic [KEY_W-1:0] key);
    send_item(KIND_LOOKUP, key);
  endtask

  function automatic logic [KEY_W-1:0] held_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // Lookup mix: held keys, their neighbours and wholly random keys.
  task automatic random_lookup();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick <= 1) lookup_key(held_key());
    else if (pick == 2) lookup_key(($urandom_range(0, 1) != 0) ? held_key() + KEY_W'(1)
                                                               : held_key() - KEY_W'(1));
    else lookup_key(random_key());
  endtask

  // Next ascending key, occasionally a duplicate of the last one.
  task automatic append_next();
    if ($urandom_range(0, 19) != 0) next_key += KEY_W'($urandom_range(1, 1 << 24));
    append_key(next_key);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, byte-order edges, duplicates, unsorted entry.
    lookup_key('0);
    lookup_key(ALL_ONES);
    append_key('0);
    lookup_key('0);
    lookup_key(40'h00_0000_0001);
    append_key(40'h00_FFFF_FFFF);
    append_key(40'h01_0000_0000);
    append_key(40'h01_0000_0000);
    append_key(40'h7F_FFFF_FFFF);
    append_key(40'h80_0000_0000);
    lookup_key(40'h00_FFFF_FFFF);
    lookup_key(40'h01_0000_0000);
    lookup_key(40'h7F_FFFF_FFFF);
    lookup_key(40'h80_0000_0000);
    lookup_key(40'h00_0000_0100);
    lookup_key(ALL_ONES);
    append_key(40'h00_0000_1000);
    lookup_key(40'h00_0000_1000);
    lookup_key(40'h80_0000_0000);
    lookup_key('0);
    next_key = 40'h80_0000_0000;

    // Random: ascending appends with a few out-of-order keys, and lookups.
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) < 2) begin
        if ($urandom_range(0, 29) == 0) append_key(random_key());
        else append_next();
      end else begin
        random_lookup();
      end
    end

    // Fill the table up to its last entry, which takes the largest key.
    while (stored_keys.size() < DEPTH - 1) begin
      append_next();
      if (stored_keys.size() % 1024 == 0) random_lookup();
    end
    append_key(ALL_ONES);

    // Full table: appends are refused, lookups search the whole depth.
    lookup_key(ALL_ONES);
    lookup_key('0);
    repeat (60) begin
      if ($urandom_range(0, 1) == 0) send_item(KIND_APPEND, random_key());
      else random_lookup();
    end

    // Drain every outstanding result, then allow for the search latency.
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sktab_pkg.sv
sv/sktab_front.sv
sv/sktab_back.sv
sv/sorted_key_table_search_core.sv
dv/sktab_checker.sv
dv/tb_top.sv
